@@ rtl/gvc_pkg.sv @@
// Package for the grid visit counter: grid geometry, field widths, codes,
// shared structs and saturation helpers. Depends on nothing.
package gvc_pkg;

    // Grid geometry and counter width.
    localparam int GRID_X     = 64;
    localparam int GRID_Y     = 64;
    localparam int COUNT_BITS = 16;

    localparam int NUM_CELLS = GRID_X * GRID_Y;
    localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int TOT_W     = $clog2(NUM_CELLS + 1);

    // Field widths of the channels.
    localparam int OP_W    = 2;
    localparam int POS_W   = 10;
    localparam int SHIFT_W = 3;
    localparam int TICK_W  = 16;
    localparam int CELLS_W = 13;
    localparam int REG_W   = 2;
    localparam int DATA_W  = 10;

    localparam longint TICK_MAX  = 64'd65535;
    localparam longint CELLS_MAX = 64'd8191;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0]   WIN_W_RESET = 10'd400;
    localparam logic [POS_W-1:0]   WIN_H_RESET = 10'd400;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd4;

    // Operation codes; the unused code behaves as a query.
    typedef enum logic [OP_W-1:0] {
        OP_VISIT = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Configuration register indexes.
    typedef enum logic [REG_W-1:0] {
        REG_WIN_W = 2'd0,
        REG_WIN_H = 2'd1,
        REG_SHIFT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0]   win_w;
        logic [POS_W-1:0]   win_h;
        logic [SHIFT_W-1:0] shift;
    } t_cfg;

    // Status of the clearing pass as seen by the datapath.
    typedef struct packed {
        logic             active;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
    } t_sweep;

    // Counts wider than the result field show as the field's maximum.
    function automatic logic [TICK_W-1:0] sat_tick(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return (w > TICK_MAX) ? TICK_W'(TICK_MAX) : w[TICK_W-1:0];
    endfunction

    function automatic logic [CELLS_W-1:0] sat_cells(input logic [TOT_W-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return (w > CELLS_MAX) ? CELLS_W'(CELLS_MAX) : w[CELLS_W-1:0];
    endfunction

endpackage

@@ rtl/gvc_req_if.sv @@
// Request channel of the grid visit counter: operation and position.
// Depends on gvc_pkg.
interface gvc_req_if;
    import gvc_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;

    modport source (output valid, output op, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input op, input x_pos, input y_pos, output ready);
endinterface

@@ rtl/gvc_rsp_if.sv @@
// Result channel of the grid visit counter: cell count, flags and total.
// Depends on gvc_pkg.
interface gvc_rsp_if;
    import gvc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TICK_W-1:0]  tick_count;
    logic               visited;
    logic               out_of_range;
    logic [CELLS_W-1:0] cells_visited;

    modport source (output valid, output tick_count, output visited,
                    output out_of_range, output cells_visited, input ready);
    modport sink   (input valid, input tick_count, input visited,
                    input out_of_range, input cells_visited, output ready);
endinterface

@@ rtl/gvc_cfg_if.sv @@
// Configuration write channel of the grid visit counter.
// Depends on gvc_pkg.
interface gvc_cfg_if;
    import gvc_pkg::*;

    logic              valid;
    logic              ready;
    logic [REG_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/gvc_cfg_regs.sv @@
// Configuration registers of the grid visit counter: window and cell size.
// Depends on gvc_pkg and gvc_cfg_if.
module gvc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gvc_cfg_if.sink       i_cfg,
    output gvc_pkg::t_cfg o_cfg
);
    import gvc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Decode the register index; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_WIN_W: n_cfg.win_w = i_cfg.data[POS_W-1:0];
                REG_WIN_H: n_cfg.win_h = i_cfg.data[POS_W-1:0];
                REG_SHIFT: n_cfg.shift = i_cfg.data[SHIFT_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_w <= WIN_W_RESET;
            r_cfg.win_h <= WIN_H_RESET;
            r_cfg.shift <= SHIFT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/gvc_cell_ram.sv @@
// Counter memory of the grid visit counter: one write port and one read port
// with registered read data. Depends on gvc_pkg.
module gvc_cell_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [gvc_pkg::IDX_W-1:0]      i_waddr,
    input  logic [gvc_pkg::COUNT_BITS-1:0] i_wdata,
    input  logic                           i_re,
    input  logic [gvc_pkg::IDX_W-1:0]      i_raddr,
    output logic [gvc_pkg::COUNT_BITS-1:0] o_rdata
);
    import gvc_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [NUM_CELLS];
    logic [COUNT_BITS-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gvc_clear_seq.sv @@
// Clearing sequencer of the grid visit counter: walks every cell once after
// reset and after each clear request. Depends on gvc_pkg.
module gvc_clear_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output gvc_pkg::t_sweep o_sweep
);
    import gvc_pkg::*;

    logic             r_active;
    logic [IDX_W-1:0] r_addr;
    logic             last;

    assign last = (r_addr == IDX_W'(NUM_CELLS - 1));

    // The pass starts at cell zero and stops after the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_addr   <= '0;
        end else if (r_active) begin
            r_active <= !last;
            r_addr   <= last ? '0 : r_addr + 1'b1;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_addr   <= '0;
        end
    end

    assign o_sweep.active = r_active;
    assign o_sweep.wr_en  = r_active;
    assign o_sweep.addr   = r_addr;
endmodule

@@ rtl/grid_visit_counter.sv @@
// Grid visit counter: when the result side keeps up, a new request is taken
// every cycle; a visit is a read-modify-write of the counter memory, read when
// the request is taken and written when it leaves stage one, with the result of
// the previous request forwarded when both address the same cell. A clear
// request answers at once and then starts a pass over all 4096 cells, one cell
// per cycle, during which no request is taken; the same pass runs after reset.
// Configuration writes are taken in every cycle and apply to requests accepted
// afterwards. Depends on gvc_pkg, the channel interfaces, gvc_cfg_regs,
// gvc_cell_ram and gvc_clear_seq.
module grid_visit_counter (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gvc_req_if.sink  i_req,
    gvc_rsp_if.source o_rsp,
    gvc_cfg_if.sink  i_cfg
);
    import gvc_pkg::*;

    t_cfg   cfg;
    t_sweep sweep;

    // Stage one: request waiting for its memory read.
    logic                  r_s1_valid;
    t_op                   r_s1_op;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_s1_oor;
    logic                  r_s1_fwd;
    logic [COUNT_BITS-1:0] r_s1_fwd_data;

    logic [TOT_W-1:0]      r_total;
    logic [TOT_W-1:0]      n_total;

    // Output register.
    logic                  r_out_valid;
    logic [TICK_W-1:0]     r_out_tick;
    logic                  r_out_visited;
    logic                  r_out_oor;
    logic [CELLS_W-1:0]    r_out_cells;

    logic                  accept;
    logic                  s1_adv;
    logic [POS_W-1:0]      cx;
    logic [POS_W-1:0]      cy;
    logic                  req_oor;
    logic [IDX_W-1:0]      req_idx;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur;
    logic                  inc;
    logic [COUNT_BITS-1:0] new_count;
    logic                  s1_we;
    logic                  is_clear;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    gvc_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (i_cfg),
        .o_cfg  (cfg)
    );

    gvc_clear_seq u_clear (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(s1_adv && is_clear),
        .o_sweep(sweep)
    );

    gvc_cell_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (accept),
        .i_raddr(req_idx),
        .o_rdata(rd_data)
    );

    // Handshake: stage one moves on when the output register is free or
    // being emptied; a clear in stage one holds back the next request.
    assign s1_adv = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !sweep.active && !(r_s1_valid && is_clear)
                         && (!r_s1_valid || s1_adv);
    assign accept = i_req.valid && i_req.ready;

    // Quantise the position to a cell and check the window and grid bounds.
    assign cx = i_req.x_pos >> cfg.shift;
    assign cy = i_req.y_pos >> cfg.shift;
    assign req_oor = (i_req.x_pos > cfg.win_w) || (i_req.y_pos > cfg.win_h)
                     || (32'(cx) >= 32'(GRID_X)) || (32'(cy) >= 32'(GRID_Y));
    assign req_idx = IDX_W'(32'(cx) * 32'(GRID_Y) + 32'(cy));

    // Stage one register, with forwarding of a write to the same cell that
    // completes at the edge on which this request reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= t_op'(i_req.op);
            r_s1_idx      <= req_idx;
            r_s1_oor      <= req_oor;
            r_s1_fwd      <= s1_we && (r_s1_idx == req_idx);
            r_s1_fwd_data <= new_count;
        end
    end

    // Modify: a visit in range adds one unless the counter is already at its maximum.
    assign is_clear  = (r_s1_op == OP_CLEAR);
    assign cur       = r_s1_fwd ? r_s1_fwd_data : rd_data;
    assign inc       = (r_s1_op == OP_VISIT) && !r_s1_oor && (cur != '1);
    assign new_count = cur + COUNT_BITS'(inc);
    assign s1_we     = s1_adv && inc;

    always_comb begin
        n_total = r_total;
        if (s1_adv && is_clear) begin
            n_total = '0;
        end else if (s1_we && (cur == '0)) begin
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // Write port: the clearing pass owns it while it runs.
    assign mem_we    = sweep.wr_en || s1_we;
    assign mem_waddr = sweep.active ? sweep.addr : r_s1_idx;
    assign mem_wdata = sweep.active ? '0 : new_count;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (is_clear || r_s1_oor) begin
                r_out_tick    <= '0;
                r_out_visited <= 1'b0;
            end else begin
                r_out_tick    <= sat_tick(new_count);
                r_out_visited <= (new_count != '0);
            end
            r_out_oor   <= r_s1_oor && !is_clear;
            r_out_cells <= sat_cells(n_total);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.tick_count    = r_out_tick;
    assign o_rsp.visited       = r_out_visited;
    assign o_rsp.out_of_range  = r_out_oor;
    assign o_rsp.cells_visited = r_out_cells;

    // No request is taken while the clearing pass runs.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep.active |-> !accept)
        else $error("request accepted during clearing pass");

    // The datapath never writes while the clearing pass owns the port.
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep.active |-> !s1_we)
        else $error("datapath write during clearing pass");

    // The visited total never exceeds the number of cells.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(NUM_CELLS))
        else $error("visited total beyond cell count");

    // A first visit to a cell adds exactly one to the total.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_we && (cur == '0)) |=> (r_total == $past(r_total) + 1'b1))
        else $error("visited total not incremented on first visit");
endmodule
